// ----- rtl/vmt_pkg.sv -----
package vmt_pkg;

   localparam int COORD_W    = 32;
   localparam int COEF_W     = 16;
   localparam int ROW_W      = 4 * COEF_W;
   localparam int PROD_W     = COORD_W + COEF_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int FRAC_SHIFT = 8;
   localparam int R_W        = SUM_W - FRAC_SHIFT;
   localparam int SIZE_W     = 15;
   localparam int VP_W       = R_W + 1 + SIZE_W + 1;
   localparam int WIN_W      = VP_W - 1;
   localparam int ONE_Q16    = 65536;

   localparam logic [2:0] CSR_ROW0        = 3'd0;
   localparam logic [2:0] CSR_ROW1        = 3'd1;
   localparam logic [2:0] CSR_ROW2        = 3'd2;
   localparam logic [2:0] CSR_ROW3        = 3'd3;
   localparam logic [2:0] CSR_VP_WIDTH    = 3'd4;
   localparam logic [2:0] CSR_VP_HEIGHT   = 3'd5;
   localparam logic [2:0] CSR_VP_ENABLE   = 3'd6;

   localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
   localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
   localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
   localparam logic [ROW_W-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;
   localparam logic [SIZE_W-1:0] VP_WIDTH_RESET  = 15'd640;
   localparam logic [SIZE_W-1:0] VP_HEIGHT_RESET = 15'd480;

   localparam logic signed [COORD_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] Q16_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
      logic signed [COORD_W-1:0] in_w;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic signed [COORD_W-1:0] out_w;
      logic                      saturated;
   } rsp_type;

   typedef logic signed [R_W-1:0] r_word_type;

   // column results after the Q26.24 -> Q26.16 floor shift, not yet clamped
   typedef struct packed {
      r_word_type rx;
      r_word_type ry;
      r_word_type rz;
      r_word_type rw;
   } mac_out_type;

   typedef struct packed {
      logic              enable;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } vp_cfg_type;

   // {clamped flag, Q16.16 value}
   function automatic logic [COORD_W:0] sat32(input logic signed [WIN_W-1:0] v);
      logic ovf;
      ovf = (v[WIN_W-1:COORD_W-1] != {(WIN_W-COORD_W+1){v[WIN_W-1]}});
      if (ovf) begin
         return {1'b1, v[WIN_W-1] ? Q16_MIN : Q16_MAX};
      end
      return {1'b0, v[COORD_W-1:0]};
   endfunction

endpackage

// ----- rtl/vmt_mac.sv -----
module vmt_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  vmt_pkg::req_type                 in_data,
   input  logic [3:0][vmt_pkg::ROW_W-1:0]   coef,
   output logic                             out_valid,
   input  logic                             out_ready,
   output vmt_pkg::mac_out_type             out_data
);
   import vmt_pkg::*;

   logic signed [COORD_W-1:0] vin [4];
   logic signed [PROD_W-1:0]  prod_in [4][4];
   logic signed [PROD_W-1:0]  prod_ff [4][4];
   logic signed [SUM_W-1:0]   sum_c [4];
   r_word_type                r_in [4];
   r_word_type                r_ff [4];
   logic                      s1_valid_ff, s2_valid_ff;
   logic                      s1_adv, s2_adv;

   assign vin[0] = in_data.in_x;
   assign vin[1] = in_data.in_y;
   assign vin[2] = in_data.in_z;
   assign vin[3] = in_data.in_w;

   assign s2_adv   = !s2_valid_ff || out_ready;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   // stage 1: sixteen 32x16 products, row i of the matrix scales input i
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i][j] = vin[i] * $signed(coef[i][COEF_W*j +: COEF_W]);
         end
      end
   end

   // stage 2: column sums, floor to Q26.16
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sum_c[j] = {{(SUM_W-PROD_W){prod_ff[0][j][PROD_W-1]}}, prod_ff[0][j]}
                  + {{(SUM_W-PROD_W){prod_ff[1][j][PROD_W-1]}}, prod_ff[1][j]}
                  + {{(SUM_W-PROD_W){prod_ff[2][j][PROD_W-1]}}, prod_ff[2][j]}
                  + {{(SUM_W-PROD_W){prod_ff[3][j][PROD_W-1]}}, prod_ff[3][j]};
         r_in[j] = sum_c[j][SUM_W-1:FRAC_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= in_valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && in_valid) begin
         prod_ff <= prod_in;
      end
      if (s2_adv && s1_valid_ff) begin
         r_ff <= r_in;
      end
   end

   assign out_valid   = s2_valid_ff;
   assign out_data.rx = r_ff[0];
   assign out_data.ry = r_ff[1];
   assign out_data.rz = r_ff[2];
   assign out_data.rw = r_ff[3];

endmodule

// ----- rtl/vmt_viewport.sv -----
module vmt_viewport (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vmt_pkg::mac_out_type  in_data,
   input  vmt_pkg::vp_cfg_type   cfg,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vmt_pkg::rsp_type      out_data
);
   import vmt_pkg::*;

   logic signed [R_W:0]      bias_x, bias_y;
   logic signed [VP_W-1:0]   vpx_in, vpy_in;
   logic signed [VP_W-1:0]   vpx_ff, vpy_ff;
   r_word_type               rz_ff, rw_ff;
   logic [COORD_W:0]         cx, cy, cz, cw;
   rsp_type                  rsp_in, rsp_ff;
   logic                     s3_valid_ff, s4_valid_ff;
   logic                     s3_adv, s4_adv;

   assign s4_adv   = !s4_valid_ff || out_ready;
   assign s3_adv   = !s3_valid_ff || s4_adv;
   assign in_ready = s3_adv;

   // stage 3: (v + 1.0) * size if enabled, else 2 * v, kept doubled so stage 4 always halves
   always_comb begin
      bias_x = {in_data.rx[R_W-1], in_data.rx} + (R_W+1)'(ONE_Q16);
      bias_y = {in_data.ry[R_W-1], in_data.ry} + (R_W+1)'(ONE_Q16);
      if (cfg.enable) begin
         vpx_in = bias_x * $signed({1'b0, cfg.width});
         vpy_in = bias_y * $signed({1'b0, cfg.height});
      end else begin
         vpx_in = {{(VP_W-R_W-1){in_data.rx[R_W-1]}}, in_data.rx, 1'b0};
         vpy_in = {{(VP_W-R_W-1){in_data.ry[R_W-1]}}, in_data.ry, 1'b0};
      end
   end

   // stage 4: halve (floor) and clamp
   always_comb begin
      cx = sat32(vpx_ff[VP_W-1:1]);
      cy = sat32(vpy_ff[VP_W-1:1]);
      cz = sat32({{(WIN_W-R_W){rz_ff[R_W-1]}}, rz_ff});
      cw = sat32({{(WIN_W-R_W){rw_ff[R_W-1]}}, rw_ff});
      rsp_in.out_x     = cx[COORD_W-1:0];
      rsp_in.out_y     = cy[COORD_W-1:0];
      rsp_in.out_z     = cz[COORD_W-1:0];
      rsp_in.out_w     = cw[COORD_W-1:0];
      rsp_in.saturated = cx[COORD_W] | cy[COORD_W] | cz[COORD_W] | cw[COORD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_adv) s3_valid_ff <= in_valid;
         if (s4_adv) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv && in_valid) begin
         vpx_ff <= vpx_in;
         vpy_ff <= vpy_in;
         rz_ff  <= in_data.rz;
         rw_ff  <= in_data.rw;
      end
      if (s4_adv && s3_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = rsp_ff;

endmodule

// ----- rtl/vertex_matrix_transform.sv -----
// Transforms one homogeneous Q16.16 vertex per clock by a 4x4 Q8.8 matrix,
// with optional viewport mapping of x and y and clamping to Q16.16. The
// datapath is four register stages (products, column sums, viewport multiply,
// clamp into the output register); a beat passes through them in that order,
// and a new beat is taken every cycle while no stage is held by backpressure;
// each stage holds its beat under backpressure and bubbles close up.
// Matrix and viewport registers must only be written while the block is empty.
module vertex_matrix_transform (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  vmt_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output vmt_pkg::rsp_type     rsp_data,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [vmt_pkg::ROW_W-1:0] csr_wdata
);
   import vmt_pkg::*;

   logic [3:0][ROW_W-1:0] coef_ff;
   logic [SIZE_W-1:0]     vpw_ff, vph_ff;
   logic                  vpen_ff;
   vp_cfg_type            vp_cfg;
   mac_out_type           mac_data;
   logic                  mac_valid, mac_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= ROW0_RESET;
         coef_ff[1] <= ROW1_RESET;
         coef_ff[2] <= ROW2_RESET;
         coef_ff[3] <= ROW3_RESET;
         vpw_ff     <= VP_WIDTH_RESET;
         vph_ff     <= VP_HEIGHT_RESET;
         vpen_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW0:      coef_ff[0] <= csr_wdata;
            CSR_ROW1:      coef_ff[1] <= csr_wdata;
            CSR_ROW2:      coef_ff[2] <= csr_wdata;
            CSR_ROW3:      coef_ff[3] <= csr_wdata;
            CSR_VP_WIDTH:  vpw_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_VP_HEIGHT: vph_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_VP_ENABLE: vpen_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign vp_cfg.enable = vpen_ff;
   assign vp_cfg.width  = vpw_ff;
   assign vp_cfg.height = vph_ff;

   vmt_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .coef      (coef_ff),
      .out_valid (mac_valid),
      .out_ready (mac_ready),
      .out_data  (mac_data)
   );

   vmt_viewport u_viewport (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mac_valid),
      .in_ready  (mac_ready),
      .in_data   (mac_data),
      .cfg       (vp_cfg),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a ready result side lets every stage advance, so the input must be open
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while result side ready");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.out_x == Q16_MAX || rsp_data.out_x == Q16_MIN ||
          rsp_data.out_y == Q16_MAX || rsp_data.out_y == Q16_MIN ||
          rsp_data.out_z == Q16_MAX || rsp_data.out_z == Q16_MIN ||
          rsp_data.out_w == Q16_MAX || rsp_data.out_w == Q16_MIN))
      else $error("saturated flag without a clamped component");

endmodule
